[rtl/core/length_prefixed_frame_receiver_assert.svh]
// Assertion macros used by the frame receiver RTL.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH

// Check a property at every rising edge outside reset.
`define LPFR_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lpfr: assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define LPFR_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lpfr: assertion failed");

`endif

[rtl/core/lpfr_pkg.sv]
package lpfr_pkg;

   // Fixed payload run per frame
   localparam int PAYLOAD_LEN = 64;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 6;
   localparam int SIZE_W  = 16;
   localparam int CRC_W   = 32;

   // Last payload index, folded into the counter width
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PAYLOAD_LEN - 1);

   // Counter values that end the size and CRC phases
   localparam logic [CNT_W-1:0] SIZE_LAST = CNT_W'(1);
   localparam logic [CNT_W-1:0] CRC_LAST  = CNT_W'(3);

   // Response kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_FRAME   = 1'b1;

   typedef enum logic [1:0] {
      PH_SIZE = 2'd0,
      PH_DATA = 2'd1,
      PH_CRC  = 2'd2
   } phase_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data;
      logic [CNT_W-1:0]  byte_index;
      logic [SIZE_W-1:0] frame_size;
      logic [CRC_W-1:0]  frame_crc;
      logic              size_exceeds;
   } rsp_type;

endpackage

[rtl/core/length_prefixed_frame_receiver.sv]
// Length-prefixed frame receiver.
// Request channel (req_valid, req_stall, req_rx_byte) takes one received byte
// per request. A frame is a 2-byte big-endian size, 64 payload bytes and a
// 4-byte big-endian CRC word. Response channel (rsp_valid, rsp_stall, rsp_*)
// gives one payload response for each payload byte whose index is below the
// announced size, and one frame-complete response (size, CRC word, over-size
// flag) on the last CRC byte. Other bytes give no response.
// Each response is registered, in the skid register while one already waits.
// Throughput: one request per cycle while req_stall is low; the frame state
// update is a single shift or counter step, done in the accept cycle.
// A response register plus a one-entry skid register sit on the response
// side, so requests keep flowing while one response waits; req_stall rises
// only once the skid register is occupied, and drops as the response side
// drains. A stalled response holds its payload.
// Reset (synchronous, active high) clears the frame state to the size phase
// and empties both response registers; the block is ready the next cycle.
`include "length_prefixed_frame_receiver_assert.svh"

module length_prefixed_frame_receiver (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lpfr_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic [lpfr_pkg::BYTE_W-1:0] rsp_data,
   output logic [lpfr_pkg::CNT_W-1:0]  rsp_byte_index,
   output logic [lpfr_pkg::SIZE_W-1:0] rsp_frame_size,
   output logic [lpfr_pkg::CRC_W-1:0]  rsp_frame_crc,
   output logic                        rsp_size_exceeds
);
   import lpfr_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [SIZE_W-1:0] size_acc_ff, size_acc_in;
   logic [CRC_W-1:0]  crc_acc_ff, crc_acc_in;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_type           skid_ff, skid_in;

   logic              accept;
   logic              pop;
   logic              hit;
   rsp_type           result;
   logic [CRC_W-1:0]  crc_shift;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;
   assign crc_shift = {crc_acc_ff[CRC_W-BYTE_W-1:0], req_rx_byte};

   // Advance the frame state and form the response for this request
   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      size_acc_in   = size_acc_ff;
      crc_acc_in    = crc_acc_ff;
      hit           = 1'b0;
      result        = '0;
      case (phase_ff)
         PH_DATA: begin
            if (SIZE_W'(byte_count_ff) < size_acc_ff) begin
               hit               = 1'b1;
               result.kind       = KIND_PAYLOAD;
               result.data       = req_rx_byte;
               result.byte_index = byte_count_ff;
            end
            if (byte_count_ff >= LAST_IDX) begin
               byte_count_in = '0;
               phase_in      = PH_CRC;
            end else begin
               byte_count_in = byte_count_ff + CNT_W'(1);
            end
         end
         PH_CRC: begin
            if (byte_count_ff >= CRC_LAST) begin
               hit                 = 1'b1;
               result.kind         = KIND_FRAME;
               result.frame_size   = size_acc_ff;
               result.frame_crc    = crc_shift;
               result.size_exceeds = (size_acc_ff > SIZE_W'(PAYLOAD_LEN));
               byte_count_in       = '0;
               size_acc_in         = '0;
               crc_acc_in          = '0;
               phase_in            = PH_SIZE;
            end else begin
               crc_acc_in    = crc_shift;
               byte_count_in = byte_count_ff + CNT_W'(1);
            end
         end
         default: begin
            // Size phase; the unused code behaves the same
            phase_in    = PH_SIZE;
            size_acc_in = {size_acc_ff[SIZE_W-BYTE_W-1:0], req_rx_byte};
            if (byte_count_ff >= SIZE_LAST) begin
               byte_count_in = '0;
               phase_in      = PH_DATA;
            end else begin
               byte_count_in = byte_count_ff + CNT_W'(1);
            end
         end
      endcase
   end

   // Steer responses through the output and skid registers
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && hit;
            out_in       = result;
         end
      end else if (accept && hit) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   // Hold frame state; update only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         byte_count_ff <= '0;
         size_acc_ff   <= '0;
         crc_acc_ff    <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         size_acc_ff   <= size_acc_in;
         crc_acc_ff    <= crc_acc_in;
      end
   end

   // Response valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Response payloads
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_data         = out_ff.data;
   assign rsp_byte_index   = out_ff.byte_index;
   assign rsp_frame_size   = out_ff.frame_size;
   assign rsp_frame_crc    = out_ff.frame_crc;
   assign rsp_size_exceeds = out_ff.size_exceeds;

   `LPFR_ASSERT(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff)
   `LPFR_ASSERT(a_size_count, clock, reset, (phase_ff != PH_SIZE) || (byte_count_ff <= SIZE_LAST))
   `LPFR_ASSERT(a_crc_count, clock, reset, (phase_ff != PH_CRC) || (byte_count_ff <= CRC_LAST))
   `LPFR_ASSERT_NEXT(a_frame_clears, clock, reset, accept && phase_ff == PH_CRC && byte_count_ff == CRC_LAST, phase_ff == PH_SIZE && size_acc_ff == '0 && crc_acc_ff == '0 && out_valid_ff)

endmodule

[bench/tb_length_prefixed_frame_receiver.sv]
module tb_length_prefixed_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   import lpfr_pkg::*;

   localparam int CLK_PERIOD   = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TOTAL_BYTES  = 1200;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {
      FILL_ZERO,
      FILL_ONES,
      FILL_INDEX,
      FILL_RANDOM
   } fill_type;

   typedef struct {
      logic [SIZE_W-1:0] size;
      logic [CRC_W-1:0]  crc;
      fill_type          fill;
      logic              exceeds;
   } frame_row_type;

   // Directed frames; the frame-complete response of each row is typed in here
   localparam int N_DIRECTED = 8;
   frame_row_type directed_rows [N_DIRECTED] = '{
      '{16'h0000, 32'h0000_0000, FILL_ZERO,   1'b0},
      '{16'h0040, 32'hFFFF_FFFF, FILL_ONES,   1'b0},
      '{16'h0041, 32'h1234_5678, FILL_INDEX,  1'b1},
      '{16'hFFFF, 32'hA5A5_A5A5, FILL_RANDOM, 1'b1},
      '{16'h0001, 32'h8000_0001, FILL_ZERO,   1'b0},
      '{16'h0100, 32'h5A5A_5A5A, FILL_ONES,   1'b1},
      '{16'h003F, 32'h0000_00FF, FILL_INDEX,  1'b0},
      '{16'h8000, 32'hDEAD_BEEF, FILL_RANDOM, 1'b1}
   };

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic                rsp_kind;
   logic [BYTE_W-1:0]   rsp_data;
   logic [CNT_W-1:0]    rsp_byte_index;
   logic [SIZE_W-1:0]   rsp_frame_size;
   logic [CRC_W-1:0]    rsp_frame_crc;
   logic                rsp_size_exceeds;

   // Frame state as the deframer should hold it
   phase_type           rx_phase = PH_SIZE;
   logic [CNT_W-1:0]    rx_count = '0;
   logic [SIZE_W-1:0]   rx_size  = '0;
   logic [CRC_W-1:0]    rx_crc   = '0;

   rsp_type             awaited_rsp [$];
   int                  errors        = 0;
   int                  cycle_count   = 0;
   int                  payload_seen  = 0;
   int                  frames_seen   = 0;
   int                  oversize_seen = 0;
   int                  frames_sent   = 0;
   int                  bytes_sent    = 0;
   int                  req_quiet     = 0;
   int                  rsp_quiet     = 0;

   length_prefixed_frame_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_size   (rsp_frame_size),
      .rsp_frame_crc    (rsp_frame_crc),
      .rsp_size_exceeds (rsp_size_exceeds)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Draw a random wait, with occasional stretches of none at all
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         quiet_left = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   // Advance the frame state by one byte; return 1 with the response it causes
   function automatic bit absorb_byte(input logic [BYTE_W-1:0] b, output rsp_type r);
      bit hit;
      hit = 1'b0;
      r   = '0;
      case (rx_phase)
         PH_DATA: begin
            if ({{(SIZE_W-CNT_W){1'b0}}, rx_count} < rx_size) begin
               r.kind       = KIND_PAYLOAD;
               r.data       = b;
               r.byte_index = rx_count;
               hit          = 1'b1;
            end
            if (rx_count >= LAST_IDX) begin
               rx_count = '0;
               rx_phase = PH_CRC;
            end else begin
               rx_count = rx_count + CNT_W'(1);
            end
         end
         PH_CRC: begin
            rx_crc = {rx_crc[CRC_W-9:0], b};
            if (rx_count >= CRC_LAST) begin
               r.kind         = KIND_FRAME;
               r.frame_size   = rx_size;
               r.frame_crc    = rx_crc;
               r.size_exceeds = (rx_size > PAYLOAD_LEN);
               hit            = 1'b1;
               rx_count       = '0;
               rx_size        = '0;
               rx_crc         = '0;
               rx_phase       = PH_SIZE;
            end else begin
               rx_count = rx_count + CNT_W'(1);
            end
         end
         default: begin
            // unused phase code falls back to the size phase
            rx_phase = PH_SIZE;
            rx_size  = {rx_size[7:0], b};
            if (rx_count >= SIZE_LAST) begin
               rx_count = '0;
               rx_phase = PH_DATA;
            end else begin
               rx_count = rx_count + CNT_W'(1);
            end
         end
      endcase
      return hit;
   endfunction

   // Drive one request and wait for it to be accepted
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed_valid,
                            input rsp_type typed);
      int      gap;
      rsp_type r;
      gap = draw_wait(req_quiet);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (absorb_byte(b, r)) begin
         awaited_rsp.push_back(typed_valid ? typed : r);
      end
   endtask

   // Send a whole frame; the typed response, if given, replaces the predicted one
   task automatic send_frame(input logic [SIZE_W-1:0] size, input logic [CRC_W-1:0] crc,
                             input fill_type fill, input bit typed_valid,
                             input rsp_type typed);
      logic [BYTE_W-1:0] b;
      rsp_type           none;
      none = '0;
      send_byte(size[15:8], 1'b0, none);
      send_byte(size[7:0], 1'b0, none);
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         case (fill)
            FILL_ZERO:  b = 8'h00;
            FILL_ONES:  b = 8'hFF;
            FILL_INDEX: b = BYTE_W'(i);
            default:    b = BYTE_W'($urandom);
         endcase
         send_byte(b, 1'b0, none);
      end
      send_byte(crc[31:24], 1'b0, none);
      send_byte(crc[23:16], 1'b0, none);
      send_byte(crc[15:8], 1'b0, none);
      send_byte(crc[7:0], typed_valid, typed);
      frames_sent++;
   endtask

   // Stall the response side for a drawn number of cycles before each response
   initial begin
      int n;
      forever begin
         n = draw_wait(rsp_quiet);
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic report_field(input string name, input logic [CRC_W-1:0] exp_val,
                               input logic [CRC_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name,
                  exp_val, act_val);
         errors++;
      end
   endtask

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response, kind %b data %h index %0d size %h crc %h",
                     $realtime, rsp_kind, rsp_data, rsp_byte_index, rsp_frame_size,
                     rsp_frame_crc);
            errors++;
         end else begin
            want = awaited_rsp.pop_front();
            report_field("kind", CRC_W'(want.kind), CRC_W'(rsp_kind));
            report_field("data", CRC_W'(want.data), CRC_W'(rsp_data));
            report_field("byte_index", CRC_W'(want.byte_index), CRC_W'(rsp_byte_index));
            report_field("frame_size", CRC_W'(want.frame_size), CRC_W'(rsp_frame_size));
            report_field("frame_crc", want.frame_crc, rsp_frame_crc);
            report_field("size_exceeds", CRC_W'(want.size_exceeds),
                         CRC_W'(rsp_size_exceeds));
         end
         if (rsp_kind == KIND_FRAME) begin
            frames_seen++;
            if (rsp_size_exceeds) oversize_seen++;
         end else begin
            payload_seen++;
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $realtime,
                  awaited_rsp.size());
         $display("length_prefixed_frame_receiver regression: fail");
         $finish;
      end
   end

   initial begin
      rsp_type          typed;
      logic [SIZE_W-1:0] size;
      int                pick;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed frames
      for (int i = 0; i < N_DIRECTED; i++) begin
         typed              = '0;
         typed.kind         = KIND_FRAME;
         typed.frame_size   = directed_rows[i].size;
         typed.frame_crc    = directed_rows[i].crc;
         typed.size_exceeds = directed_rows[i].exceeds;
         send_frame(directed_rows[i].size, directed_rows[i].crc, directed_rows[i].fill,
                    1'b1, typed);
      end

      // Random frames: mostly in-range sizes, with the boundaries and oversize mixed in
      typed = '0;
      while (bytes_sent < TOTAL_BYTES) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: size = SIZE_W'($urandom_range(0, PAYLOAD_LEN));
            4:          size = '0;
            5:          size = SIZE_W'($urandom_range(PAYLOAD_LEN - 1, PAYLOAD_LEN + 1));
            6:          size = SIZE_W'($urandom_range(PAYLOAD_LEN + 1, 255));
            7:          size = SIZE_W'($urandom);
            default:    size = SIZE_W'($urandom_range(1, 8));
         endcase
         send_frame(size, CRC_W'($urandom), FILL_RANDOM, 1'b0, typed);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain the response side, then give stray responses a chance to show
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d frames; checked %0d payload and %0d frame responses",
               bytes_sent, frames_sent, payload_seen, frames_seen);
      $display("(%0d frames over-size), %0d mismatches", oversize_seen, errors);
      if (errors == 0) begin
         $display("length_prefixed_frame_receiver regression: pass");
      end else begin
         $display("length_prefixed_frame_receiver regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lpfr_pkg.sv
rtl/core/length_prefixed_frame_receiver.sv
bench/tb_length_prefixed_frame_receiver.sv
